FILE: hw/rtl/ncc_pkg.sv
// ----------------------------------------------------------------------------
// NCC package
// Shared constants, operation codes and back-end state type.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam int CORR_W   = 16;     // Q1.15 result width
    localparam int SRCH_W   = 17;     // search bounds, holds 0..32768
    localparam int ODD_W    = 17;     // 2*k-1 for k up to 32768
    localparam int RHS_SH   = 32;     // numerator square is scaled by 2^32
    localparam logic [SRCH_W-1:0] SRCH_TOP = 17'd32768;
    localparam logic [CORR_W-1:0] CORR_MAX = 16'd32767;

    typedef enum logic [3:0] {
        OP_NSAB = 4'd0,
        OP_SASB = 4'd1,
        OP_NSAA = 4'd2,
        OP_SASA = 4'd3,
        OP_NSBB = 4'd4,
        OP_SBSB = 4'd5,
        OP_PROD = 4'd6,
        OP_RHS  = 4'd7,
        OP_ODD  = 4'd8,
        OP_TEST = 4'd9
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } t_back_state;

endpackage

FILE: hw/rtl/ncc_front.sv
// ----------------------------------------------------------------------------
// NCC front end
// Accumulates count, sums, sums of squares and cross sum per patch and
// hands a snapshot of them to the queue on the last pair.
// ----------------------------------------------------------------------------
module ncc_front #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic [7:0] i_pixel_a,
    input  logic [7:0] i_pixel_b,
    input  logic i_last,
    input  logic i_full,
    output logic o_ready,
    output logic o_push,
    output logic [$clog2(MAX_PIXELS+1)*6+64:0] o_snap
);
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + 8;
    localparam int QW = CW + 16;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_sa, n_sa, r_sb, n_sb;
    logic [QW-1:0] r_saa, n_saa, r_sbb, n_sbb, r_sab, n_sab;
    logic r_ovf, n_ovf;
    logic w_take;

    assign o_ready = !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_push  = w_take && i_last;

    always_comb begin
        n_cnt = r_cnt;
        n_sa  = r_sa;
        n_sb  = r_sb;
        n_saa = r_saa;
        n_sbb = r_sbb;
        n_sab = r_sab;
        n_ovf = r_ovf;
        if (r_cnt < CW'(MAX_PIXELS)) begin
            n_cnt = r_cnt + 1'b1;
            n_sa  = r_sa + SW'(i_pixel_a);
            n_sb  = r_sb + SW'(i_pixel_b);
            n_saa = r_saa + QW'(i_pixel_a) * QW'(i_pixel_a);
            n_sbb = r_sbb + QW'(i_pixel_b) * QW'(i_pixel_b);
            n_sab = r_sab + QW'(i_pixel_a) * QW'(i_pixel_b);
        end else begin
            n_ovf = 1'b1;
        end
    end

    assign o_snap = {n_ovf, n_sab, n_sbb, n_saa, n_sb, n_sa, n_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_cnt <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
            r_saa <= '0;
            r_sbb <= '0;
            r_sab <= '0;
            r_ovf <= 1'b0;
        end else if (w_take) begin
            r_cnt <= n_cnt;
            r_sa  <= n_sa;
            r_sb  <= n_sb;
            r_saa <= n_saa;
            r_sbb <= n_sbb;
            r_sab <= n_sab;
            r_ovf <= n_ovf;
        end
    end
endmodule

FILE: hw/rtl/ncc_fifo.sv
// ----------------------------------------------------------------------------
// NCC queue
// Two-entry queue of patch snapshots between front and back end.
// ----------------------------------------------------------------------------
module ncc_fifo #(
    parameter int W = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic [W-1:0] i_data,
    input  logic i_pop,
    output logic [W-1:0] o_data,
    output logic o_full,
    output logic o_empty
);
    logic [W-1:0] r_mem [2];
    logic r_wptr, r_rptr;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

FILE: hw/rtl/ncc_mul.sv
// ----------------------------------------------------------------------------
// NCC multiplier
// Shift-and-add multiplier, one multiplier bit per cycle, stops early
// once the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module ncc_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    output logic o_done,
    output logic [AW+BW-1:0] o_prod
);
    logic [AW+BW-1:0] r_acc, r_ash;
    logic [BW-1:0] r_bsh;
    logic r_busy;

    assign o_done = r_busy && (r_bsh == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_ash <= (AW+BW)'(i_a);
            r_bsh <= i_b;
        end else if (r_busy) begin
            if (r_bsh[0]) begin
                r_acc <= r_acc + r_ash;
            end
            r_ash <= r_ash << 1;
            r_bsh <= r_bsh >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

FILE: hw/rtl/ncc_back.sv
// ----------------------------------------------------------------------------
// NCC back end
// Forms the covariance and variance terms, then, unless the patch is flat,
// searches the Q1.15 coefficient by bisection with exact squared comparisons.
// ----------------------------------------------------------------------------
module ncc_back #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  logic [$clog2(MAX_PIXELS+1)*6+64:0] i_snap,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic [ncc_pkg::CORR_W-1:0] o_corr,
    output logic o_flat,
    output logic o_ovf
);
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + 8;
    localparam int QW = CW + 16;
    localparam int TW = CW + QW;
    localparam int PW = 2 * TW;
    localparam int BW = (TW > 2 * ncc_pkg::ODD_W) ? TW : 2 * ncc_pkg::ODD_W;
    localparam int RW = PW + BW;
    localparam int O_SA  = CW;
    localparam int O_SB  = O_SA + SW;
    localparam int O_SAA = O_SB + SW;
    localparam int O_SBB = O_SAA + QW;
    localparam int O_SAB = O_SBB + QW;
    localparam int O_OVF = O_SAB + QW;

    ncc_pkg::t_back_state r_state;
    ncc_pkg::t_op r_op;
    logic [CW-1:0] r_n;
    logic [SW-1:0] r_sa, r_sb;
    logic [QW-1:0] r_saa, r_sbb, r_sab;
    logic [BW-1:0] r_x;
    logic [TW-1:0] r_mag, r_t1;
    logic r_neg;
    logic [PW-1:0] r_prod;
    logic [PW-1:0] r_rhs;
    logic [ncc_pkg::SRCH_W-1:0] r_lo, r_hi, r_mid;
    logic [ncc_pkg::SRCH_W:0] w_sum;
    logic [ncc_pkg::SRCH_W-1:0] w_mid;
    logic [ncc_pkg::ODD_W-1:0] w_odd;
    logic [PW-1:0] w_a;
    logic [BW-1:0] w_b;
    logic w_start, w_done;
    logic [RW-1:0] w_res;
    logic [TW:0] w_diff;
    logic [TW-1:0] w_t;

    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign w_mid = w_sum[ncc_pkg::SRCH_W:1];
    // The odd factor is formed from the midpoint of the current bounds.
    assign w_odd = {w_mid[ncc_pkg::ODD_W-2:0], 1'b0} - 1'b1;
    assign w_diff = {1'b0, r_x[TW-1:0]} - {1'b0, w_res[TW-1:0]};
    assign w_t = w_diff[TW-1:0];

    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_op)
            ncc_pkg::OP_NSAB: begin w_a = PW'(r_sab); w_b = BW'(r_n); end
            ncc_pkg::OP_SASB: begin w_a = PW'(r_sa);  w_b = BW'(r_sb); end
            ncc_pkg::OP_NSAA: begin w_a = PW'(r_saa); w_b = BW'(r_n); end
            ncc_pkg::OP_SASA: begin w_a = PW'(r_sa);  w_b = BW'(r_sa); end
            ncc_pkg::OP_NSBB: begin w_a = PW'(r_sbb); w_b = BW'(r_n); end
            ncc_pkg::OP_SBSB: begin w_a = PW'(r_sb);  w_b = BW'(r_sb); end
            ncc_pkg::OP_PROD: begin w_a = PW'(r_t1);  w_b = r_x; end
            ncc_pkg::OP_RHS:  begin w_a = PW'(r_mag); w_b = BW'(r_mag); end
            ncc_pkg::OP_ODD:  begin w_a = PW'(w_odd); w_b = BW'(w_odd); end
            ncc_pkg::OP_TEST: begin w_a = r_prod;     w_b = r_x; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_start = (r_state == ncc_pkg::ST_RUN) &&
                     !((r_op == ncc_pkg::OP_ODD) && (r_lo >= r_hi));

    ncc_mul #(.AW(PW), .BW(BW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_prod  (w_res)
    );

    assign o_pop   = (r_state == ncc_pkg::ST_IDLE) && !i_empty;
    assign o_valid = (r_state == ncc_pkg::ST_OUT);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_n   <= i_snap[CW-1:0];
            r_sa  <= i_snap[O_SA +: SW];
            r_sb  <= i_snap[O_SB +: SW];
            r_saa <= i_snap[O_SAA +: QW];
            r_sbb <= i_snap[O_SBB +: QW];
            r_sab <= i_snap[O_SAB +: QW];
            o_ovf <= i_snap[O_OVF];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncc_pkg::ST_IDLE;
            r_op    <= ncc_pkg::OP_NSAB;
        end else begin
            unique case (r_state)
                ncc_pkg::ST_IDLE: begin
                    if (!i_empty) begin
                        r_op    <= ncc_pkg::OP_NSAB;
                        r_state <= ncc_pkg::ST_RUN;
                    end
                end
                ncc_pkg::ST_RUN: begin
                    if (w_start) begin
                        r_state <= ncc_pkg::ST_WAIT;
                        if (r_op == ncc_pkg::OP_ODD) begin
                            r_mid <= w_mid;
                        end
                    end else begin
                        // Search has converged: lo is the rounded magnitude.
                        o_flat <= 1'b0;
                        if (r_neg) begin
                            o_corr <= ncc_pkg::CORR_W'(~r_lo + 1'b1);
                        end else if (r_lo > ncc_pkg::SRCH_W'(ncc_pkg::CORR_MAX)) begin
                            o_corr <= ncc_pkg::CORR_MAX;
                        end else begin
                            o_corr <= r_lo[ncc_pkg::CORR_W-1:0];
                        end
                        r_state <= ncc_pkg::ST_OUT;
                    end
                end
                ncc_pkg::ST_WAIT: begin
                    if (w_done) begin
                        r_state <= ncc_pkg::ST_RUN;
                        unique case (r_op)
                            ncc_pkg::OP_NSAB, ncc_pkg::OP_NSAA, ncc_pkg::OP_NSBB: begin
                                r_x  <= w_res[BW-1:0];
                                r_op <= ncc_pkg::t_op'(r_op + 4'd1);
                            end
                            ncc_pkg::OP_SASB: begin
                                r_neg <= w_diff[TW];
                                r_mag <= w_diff[TW] ? (~w_t + 1'b1) : w_t;
                                r_op  <= ncc_pkg::OP_NSAA;
                            end
                            ncc_pkg::OP_SASA: begin
                                r_t1 <= w_t;
                                r_op <= ncc_pkg::OP_NSBB;
                            end
                            ncc_pkg::OP_SBSB: begin
                                r_x <= BW'(w_t);
                                if ((r_t1 == '0) || (w_t == '0)) begin
                                    o_corr  <= '0;
                                    o_flat  <= 1'b1;
                                    r_state <= ncc_pkg::ST_OUT;
                                end else begin
                                    r_op <= ncc_pkg::OP_PROD;
                                end
                            end
                            ncc_pkg::OP_PROD: begin
                                r_prod <= w_res[PW-1:0];
                                r_op   <= ncc_pkg::OP_RHS;
                            end
                            ncc_pkg::OP_RHS: begin
                                r_rhs <= w_res[PW-1:0];
                                r_lo  <= '0;
                                r_hi  <= ncc_pkg::SRCH_TOP;
                                r_op  <= ncc_pkg::OP_ODD;
                            end
                            ncc_pkg::OP_ODD: begin
                                r_x  <= w_res[BW-1:0];
                                r_op <= ncc_pkg::OP_TEST;
                            end
                            ncc_pkg::OP_TEST: begin
                                if (w_res <= RW'({r_rhs, {ncc_pkg::RHS_SH{1'b0}}})) begin
                                    r_lo <= r_mid;
                                end else begin
                                    r_hi <= r_mid - 1'b1;
                                end
                                r_op <= ncc_pkg::OP_ODD;
                            end
                            default: r_state <= ncc_pkg::ST_IDLE;
                        endcase
                    end
                end
                ncc_pkg::ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ncc_pkg::ST_IDLE;
                    end
                end
                default: r_state <= ncc_pkg::ST_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/normalized_cross_correlation.sv
// Input side takes one pixel pair per cycle while the snapshot queue is not full.
// The back end forms every product on the shared shift-and-add multiplier: eight
// form the statistics, then up to sixteen search steps take two each. A two-entry
// snapshot queue lets the next patch stream in while the back end works. Synchronous
// active-low reset clears the front-end accumulators, the queue and the result valid.
// ----------------------------------------------------------------------------
// Normalized cross-correlation
// Accumulates patch statistics and emits the Q1.15 correlation per patch.
// ----------------------------------------------------------------------------
module normalized_cross_correlation #(
    parameter int MAX_PIXELS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // pixel_a [7:0], pixel_b [15:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // correlation [15:0]
    output logic [1:0]  m_axis_tuser    // flat_patch [0], count_overflow [1]
);
    localparam int SNW = $clog2(MAX_PIXELS + 1) * 6 + 65;

    logic w_push, w_pop, w_full, w_empty;
    logic [SNW-1:0] w_snap_in, w_snap_out;
    logic w_flat, w_ovf;

    ncc_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_pixel_a (s_axis_tdata[7:0]),
        .i_pixel_b (s_axis_tdata[15:8]),
        .i_last    (s_axis_tlast),
        .i_full    (w_full),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_snap    (w_snap_in)
    );

    ncc_fifo #(.W(SNW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap_in),
        .i_pop   (w_pop),
        .o_data  (w_snap_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ncc_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_snap  (w_snap_out),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_corr  (m_axis_tdata),
        .o_flat  (w_flat),
        .o_ovf   (w_ovf)
    );

    assign m_axis_tuser = {w_ovf, w_flat};

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("snapshot pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("snapshot popped from an empty queue");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_flat) |-> (m_axis_tdata == 16'd0))
        else $error("flat patch with nonzero correlation");
endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Normalized cross-correlation testbench
// Streams pixel-pair patches into the block and checks every Q1.15 result,
// flat flag and overflow flag against an exact integer model of the correlation
// or a typed table result. A directed table comes first, then random patches.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PIXELS = 1024;
    localparam int WATCHDOG   = 200000;
    localparam int DRAIN      = 12000;
    localparam int RAND_ITEMS = 1780;

    typedef struct packed {
        logic signed [15:0] corr;
        logic               flat;
        logic               ovf;
    } patch_result_t;

    typedef struct {
        logic [7:0]    a;
        logic [7:0]    b;
        logic          last;
        logic          typed;
        patch_result_t res;
    } pixel_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // pixel_a [7:0], pixel_b [15:8]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // correlation [15:0]
    logic [1:0]  m_axis_tuser;        // flat_patch [0], count_overflow [1]

    normalized_cross_correlation #(.MAX_PIXELS(MAX_PIXELS)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Running patch statistics of the model.
    longint        pair_count, sum_a, sum_b, sumsq_a, sumsq_b, sum_ab;
    logic          pairs_dropped;
    patch_result_t pending_results[$];
    int            errors = 0;
    int            idle_cycles = 0;
    logic          gaps_on = 1'b1;

    // Folds one pair into the statistics; returns 1 with the result on a last pair.
    function automatic logic accumulate_pair(input logic [7:0] a, input logic [7:0] b,
                                             input logic last, output patch_result_t r);
        longint      numer, t1, t2, mag;
        logic [127:0] prod, rhs, odd;
        int          lo, hi, mid;
        r = '0;
        if (pair_count < MAX_PIXELS) begin
            pair_count++;
            sum_a   += a;
            sum_b   += b;
            sumsq_a += a * a;
            sumsq_b += b * b;
            sum_ab  += a * b;
        end else begin
            pairs_dropped = 1'b1;
        end
        if (!last) return 1'b0;
        numer = pair_count * sum_ab - sum_a * sum_b;
        t1 = pair_count * sumsq_a - sum_a * sum_a;
        t2 = pair_count * sumsq_b - sum_b * sum_b;
        r.flat = (t1 == 0) || (t2 == 0);
        r.ovf  = pairs_dropped;
        if (!r.flat) begin
            mag  = (numer < 0) ? -numer : numer;
            prod = 128'(t1) * 128'(t2);
            rhs  = (128'(mag) * 128'(mag)) << 32;
            lo = 0;
            hi = 32768;
            // Largest k with (2k-1)^2 * var_a * var_b <= 4 * 2^30 * cov^2 scaled.
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                odd = 128'(2 * mid - 1);
                if (prod * odd * odd <= rhs) lo = mid;
                else hi = mid - 1;
            end
            if (numer < 0) r.corr = 16'(-lo);
            else r.corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
        end
        pair_count = 0; sum_a = 0; sum_b = 0;
        sumsq_a = 0; sumsq_b = 0; sum_ab = 0;
        pairs_dropped = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last,
                             input logic typed, input patch_result_t typed_res);
        patch_result_t r;
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (accumulate_pair(a, b, last, r))
            pending_results.push_back(typed ? typed_res : r);
    endtask

    always @(negedge i_clk)
        m_axis_tready <= gaps_on ? ($urandom_range(99) >= 29) : 1'b1;

    always @(posedge i_clk) begin
        patch_result_t exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transfer corr=%0d user=%b", $time,
                         $signed(m_axis_tdata), m_axis_tuser);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if ($signed(m_axis_tdata) !== exp_r.corr) begin
                    $display("%0t: correlation expected %0d actual %0d", $time,
                             exp_r.corr, $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tuser[0] !== exp_r.flat) begin
                    $display("%0t: flat_patch expected %b actual %b", $time,
                             exp_r.flat, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== exp_r.ovf) begin
                    $display("%0t: count_overflow expected %b actual %b", $time,
                             exp_r.ovf, m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    pixel_row_t directed[] = '{
        '{8'd0,   8'd0,   1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
        '{8'd255, 8'd255, 1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
        '{8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 8'd255, 1'b1, 1'b1, '{16'sd32767, 1'b0, 1'b0}},
        '{8'd0,   8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 8'd0,   1'b1, 1'b1, '{-16'sd32768, 1'b0, 1'b0}},
        '{8'd10,  8'd7,   1'b0, 1'b0, '0},
        '{8'd20,  8'd7,   1'b1, 1'b1, '{16'sd0, 1'b1, 1'b0}},
        '{8'd1,   8'd2,   1'b0, 1'b0, '0},
        '{8'd3,   8'd1,   1'b0, 1'b0, '0},
        '{8'd200, 8'd90,  1'b0, 1'b0, '0},
        '{8'd170, 8'd85,  1'b1, 1'b0, '0},
        '{8'd128, 8'd127, 1'b0, 1'b0, '0},
        '{8'd127, 8'd128, 1'b0, 1'b0, '0},
        '{8'd64,  8'd33,  1'b1, 1'b0, '0}
    };

    initial begin
        int len, done, drain;
        logic [7:0] a, b;
        pair_count = 0; sum_a = 0; sum_b = 0;
        sumsq_a = 0; sumsq_b = 0; sum_ab = 0;
        pairs_dropped = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_pair(directed[i].a, directed[i].b, directed[i].last,
                      directed[i].typed, directed[i].res);

        // Hold the sender until every directed result is out.
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);

        done = 0;
        // One patch runs past the pixel limit with no idle cycles on either side;
        // the rest are short.
        gaps_on = 1'b0;
        len = MAX_PIXELS + $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
            send_pair(8'($urandom), 8'($urandom), k == len - 1, 1'b0, '0);
        done += len;
        while (done < RAND_ITEMS) begin
            len = $urandom_range(1, 40);
            gaps_on = ($urandom_range(9) != 0);
            for (int k = 0; k < len; k++) begin
                a = 8'($urandom);
                b = 8'($urandom);
                // Some pairs are strongly related or flat on one side.
                case ($urandom_range(5))
                    0: b = a;
                    1: b = ~a;
                    2: b = 8'd77;
                    default: ;
                endcase
                send_pair(a, b, k == len - 1, 1'b0, '0);
            end
            done += len;
        end
        gaps_on = 1'b1;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        drain = 0;
        while (pending_results.size() != 0 && drain < WATCHDOG) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            if (pending_results.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_results.size());
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
